// File: rtl/vkrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkrq_pkg
// Shared types and constants of the keyframe range quantizer.
// ----------------------------------------------------------------------------
package vkrq_pkg;

    // default track store depth
    localparam int MAX_KEYS_DEF = 32;

    // 2 * 65535: numerator scale of the rounded quantizer
    localparam logic [16:0] CODE_SCALE = 17'd131070;

    // result kinds
    localparam logic [1:0] KIND_CONST  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_KEY    = 2'd2;
    localparam logic [1:0] KIND_OVF    = 2'd3;

    typedef struct packed {
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic        [15:0] frame_index;
        logic               last;
    } in_t;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] base_z;
        logic        [31:0] span_x;
        logic        [31:0] span_y;
        logic        [31:0] span_z;
        logic        [15:0] key_frame;
        logic        [15:0] code_x;
        logic        [15:0] code_y;
        logic        [15:0] code_z;
        logic               final_result;
    } out_t;

    // control from sequencer to each lane
    typedef struct packed {
        logic upd;      // accepted key is stored
        logic first;    // it is the first key of the track
        logic clr;      // track done
        logic start;    // begin quantizing one stored value
    } lane_ctl_t;

    // per-component track statistics
    typedef struct packed {
        logic signed [31:0] min;
        logic        [31:0] span;
        logic signed [31:0] first;
        logic               neq;    // some key beyond tolerance of the first
    } lane_stat_t;

endpackage

// File: rtl/vkrq_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkrq_lane
// One component: min/max/tolerance tracking and a 16-step restoring divider
// for code = round((v - min) * 65535 / span).
// ----------------------------------------------------------------------------
module vkrq_lane
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vkrq_pkg::lane_ctl_t   ctl,
    input  logic signed [31:0]    val,
    input  logic        [15:0]    tol,
    output vkrq_pkg::lane_stat_t  stat,
    output logic        [15:0]    code,
    output logic                  done
);

    localparam logic [4:0] STP_IDLE = 5'd0;
    localparam logic [4:0] STP_MUL  = 5'd1;
    localparam logic [4:0] STP_LAST = 5'd17;

    logic signed [31:0] min_reg, max_reg, first_reg;
    logic               neq_reg;
    logic        [31:0] off_reg;
    logic        [33:0] rem_reg;
    logic        [15:0] nlo_reg, q_reg;
    logic        [4:0]  stp_reg;
    logic               done_reg;

    logic [31:0] span_c;
    logic [32:0] dv_c;
    logic [32:0] dist_c;
    logic [49:0] num_c;
    logic [33:0] trial_c;
    logic        ge_c;

    // statistics of the current track
    assign span_c = max_reg - min_reg;
    assign dv_c   = {span_c, 1'b0};
    assign dist_c = (val >= first_reg)
                  ? 33'(33'(signed'(val)) - 33'(signed'(first_reg)))
                  : 33'(33'(signed'(first_reg)) - 33'(signed'(val)));

    // numerator and one divider step
    assign num_c   = 50'(off_reg) * 50'(vkrq_pkg::CODE_SCALE) + 50'(span_c);
    assign trial_c = {rem_reg[32:0], nlo_reg[15]};
    assign ge_c    = trial_c >= {1'b0, dv_c};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            first_reg <= '0;
            neq_reg   <= 1'b0;
            stp_reg   <= STP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            // key tracking
            if (ctl.clr)
            begin
                neq_reg <= 1'b0;
            end
            else if (ctl.upd)
            begin
                if (ctl.first)
                begin
                    min_reg   <= val;
                    max_reg   <= val;
                    first_reg <= val;
                    neq_reg   <= 1'b0;
                end
                else
                begin
                    if (dist_c > {17'd0, tol})
                    begin
                        neq_reg <= 1'b1;
                    end
                    if (val < min_reg)
                    begin
                        min_reg <= val;
                    end
                    if (val > max_reg)
                    begin
                        max_reg <= val;
                    end
                end
            end

            // divider sequencing
            if (ctl.start)
            begin
                stp_reg  <= STP_MUL;
                done_reg <= 1'b0;
            end
            else if (stp_reg == STP_LAST)
            begin
                stp_reg  <= STP_IDLE;
                done_reg <= 1'b1;
            end
            else if (stp_reg != STP_IDLE)
            begin
                stp_reg <= stp_reg + 5'd1;
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            off_reg <= val - min_reg;
        end
        else if (stp_reg == STP_MUL)
        begin
            rem_reg <= num_c[49:16];
            nlo_reg <= num_c[15:0];
            q_reg   <= '0;
        end
        else if (stp_reg != STP_IDLE)
        begin
            rem_reg <= ge_c ? 34'(trial_c - {1'b0, dv_c}) : trial_c;
            nlo_reg <= {nlo_reg[14:0], 1'b0};
            q_reg   <= {q_reg[14:0], ge_c};
        end
    end

    assign stat.min   = min_reg;
    assign stat.span  = span_c;
    assign stat.first = first_reg;
    assign stat.neq   = neq_reg;
    assign code       = (span_c == '0) ? 16'd0 : q_reg;
    assign done       = done_reg;

endmodule

// File: rtl/vec3_keyframe_range_quantizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_keyframe_range_quantizer_unit
// Stores a keyframe track, then emits a constant, an overflow error, or a
// range header followed by one quantized result per key.
// ----------------------------------------------------------------------------
//   channel   signals                           transfer when
//   in        in_valid, in_ready, in_data       in_valid & in_ready
//   out       out_valid, out_ready, out_data    out_valid & out_ready
//   cfg       cfg_we, cfg_data                  cfg_we
//
// Keys load at one per cycle. After the last key the track is decided, then
// each quantized key runs through store read, offset, multiply, 16 divider
// steps in three parallel lanes, and result handoff. Input is held off during
// emission.
// Reset is asynchronous; the key store is not cleared. A stalled output holds
// the emission sequence in place.
// ----------------------------------------------------------------------------
module vec3_keyframe_range_quantizer_unit
#(
    parameter int MAX_KEYS = vkrq_pkg::MAX_KEYS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  vkrq_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vkrq_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_data
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_KEYS);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_START  = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [15:0] frame;
    } entry_t;

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           ovf_reg, ovf_next;
    logic [15:0]    tol_reg;
    logic           ov_reg, ov_next;
    vkrq_pkg::out_t od_reg, od_next;

    entry_t         mem [MAX_KEYS];
    entry_t         rd_reg;

    logic           acc, store_en, out_free, last_key;
    vkrq_pkg::lane_ctl_t  ctl;
    vkrq_pkg::lane_stat_t st_x, st_y, st_z;
    logic [15:0]    c_x, c_y, c_z;
    logic [2:0]     dn;

    assign acc      = in_valid && in_ready;
    assign store_en = acc && (cnt_reg != CNT_MAX);
    assign out_free = !ov_reg || out_ready;
    assign last_key = (k_reg + CW'(1)) == cnt_reg;
    assign in_ready = (state_reg == S_LOAD);

    // key store
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[cnt_reg[AW-1:0]] <= '{in_data.value_x, in_data.value_y,
                                      in_data.value_z, in_data.frame_index};
        end
        if (state_reg == S_READ)
        begin
            rd_reg <= mem[k_reg[AW-1:0]];
        end
    end

    // lane control
    always_comb
    begin
        ctl.upd   = store_en;
        ctl.first = (cnt_reg == '0);
        ctl.start = (state_reg == S_START);
        ctl.clr   = 1'b0;
        if (state_reg == S_DECIDE && out_free &&
            (ovf_reg || !(st_x.neq || st_y.neq || st_z.neq)))
        begin
            ctl.clr = 1'b1;
        end
        if (state_reg == S_WAIT && (&dn) && out_free && last_key)
        begin
            ctl.clr = 1'b1;
        end
    end

    vkrq_lane u_lane_x (.clk(clk), .rst_n(rst_n), .ctl(ctl),
        .val(ctl.start ? rd_reg.x : in_data.value_x), .tol(tol_reg),
        .stat(st_x), .code(c_x), .done(dn[0]));
    vkrq_lane u_lane_y (.clk(clk), .rst_n(rst_n), .ctl(ctl),
        .val(ctl.start ? rd_reg.y : in_data.value_y), .tol(tol_reg),
        .stat(st_y), .code(c_y), .done(dn[1]));
    vkrq_lane u_lane_z (.clk(clk), .rst_n(rst_n), .ctl(ctl),
        .val(ctl.start ? rd_reg.z : in_data.value_z), .tol(tol_reg),
        .stat(st_z), .code(c_z), .done(dn[2]));

    // sequencer and merge of lane results
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        ovf_next   = ovf_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (acc)
                begin
                    if (store_en)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_data.last)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next = '0;
                    k_next  = '0;
                    if (ovf_reg)
                    begin
                        od_next.kind         = vkrq_pkg::KIND_OVF;
                        od_next.final_result = 1'b1;
                        state_next = S_LOAD;
                    end
                    else if (!(st_x.neq || st_y.neq || st_z.neq))
                    begin
                        od_next.kind         = vkrq_pkg::KIND_CONST;
                        od_next.base_x       = st_x.first;
                        od_next.base_y       = st_y.first;
                        od_next.base_z       = st_z.first;
                        od_next.final_result = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        od_next.kind   = vkrq_pkg::KIND_HEADER;
                        od_next.base_x = st_x.min;
                        od_next.base_y = st_y.min;
                        od_next.base_z = st_z.min;
                        od_next.span_x = st_x.span;
                        od_next.span_y = st_y.span;
                        od_next.span_z = st_z.span;
                        state_next = S_READ;
                    end
                    if (state_next == S_LOAD)
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if ((&dn) && out_free)
                begin
                    ov_next = 1'b1;
                    od_next = '0;
                    od_next.kind         = vkrq_pkg::KIND_KEY;
                    od_next.key_frame    = rd_reg.frame;
                    od_next.code_x       = c_x;
                    od_next.code_y       = c_y;
                    od_next.code_z       = c_z;
                    od_next.final_result = last_key;
                    k_next = k_reg + CW'(1);
                    if (last_key)
                    begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            k_reg     <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            tol_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

`ifndef SYNTHESIS
    // fill count stays within the store
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("key count beyond store depth");

    // lanes run in lockstep
    a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (dn[0] == dn[1]) && (dn[1] == dn[2]))
        else $error("lanes out of step");

    // no transfer right after the last key of a track
    a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.last) |=> !in_ready)
        else $error("input taken after track end");
`endif

endmodule
